// ===== hdl/wss_pkg.sv =====
// Shared constants, register indexes and the case-fold helper for the substring search block.
`timescale 1ns / 1ps

package wss_pkg;

  localparam int TERM_MAX_DEF      = 32;
  localparam int POSITION_BITS_DEF = 24;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 6;
  localparam int START_W    = 24;
  localparam int M_START_W  = 24;
  localparam int M_END_W    = 25;
  localparam int S_DATA_W   = 8;
  localparam int M_DATA_W   = 56;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TERM0      = 3'd0;
  localparam cfg_idx_t REG_TERM_LEN   = 3'd4;
  localparam cfg_idx_t REG_CASE_SENS  = 3'd5;
  localparam cfg_idx_t REG_START_POS  = 3'd6;

  localparam byte_t CHAR_UPPER_A = 8'h41;
  localparam byte_t CHAR_UPPER_Z = 8'h5A;
  localparam byte_t CASE_OFFSET  = 8'h20;

  // Fold ASCII upper case to lower unless the compare is exact.
  function automatic byte_t fold(input byte_t c, input logic case_sens);
    byte_t r;
    r = c;
    if (!case_sens && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== hdl/wss_matcher.sv =====
// Term alignment register and parallel window compare.
`timescale 1ns / 1ps

module wss_matcher #(
  parameter int TERM_MAX = wss_pkg::TERM_MAX_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [TERM_MAX-1:0][wss_pkg::BYTE_W-1:0]      term,
  input  logic [wss_pkg::LEN_W-1:0]                     term_length,
  input  logic                                          case_sensitive,
  input  logic [TERM_MAX-1:0][wss_pkg::BYTE_W-1:0]      window,
  output logic                                          hit
);

  localparam int IDX_W = (TERM_MAX > 1) ? $clog2(TERM_MAX) : 1;

  // term reversed so that aligned[i] lines up with window[i] (window[0] is newest)
  logic [TERM_MAX-1:0][wss_pkg::BYTE_W-1:0] aligned, aligned_next;
  logic [TERM_MAX-1:0]                      mask, mask_next;
  logic                                     len_ok, len_ok_next;
  logic                                     case_sens_q;
  logic [TERM_MAX-1:0]                      byte_ok;

  always_comb begin
    int j;
    len_ok_next = (term_length != '0) &&
                  (term_length <= wss_pkg::LEN_W'(TERM_MAX));
    for (int i = 0; i < TERM_MAX; i++) begin
      j = int'(term_length) - 1 - i;
      mask_next[i]    = (i < int'(term_length));
      aligned_next[i] = '0;
      if (mask_next[i] && len_ok_next) begin
        aligned_next[i] = wss_pkg::fold(term[IDX_W'(j)], case_sensitive);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_ok <= 1'b0;
    end else begin
      len_ok <= len_ok_next;
    end
    aligned     <= aligned_next;
    mask        <= mask_next;
    case_sens_q <= case_sensitive;
  end

  always_comb begin
    for (int i = 0; i < TERM_MAX; i++) begin
      byte_ok[i] = !mask[i] || (wss_pkg::fold(window[i], case_sens_q) == aligned[i]);
    end
    hit = len_ok && (&byte_ok);
  end

endmodule

// ===== hdl/wrapping_substring_search.sv =====
// Top level: streaming substring search with wrap-around match preference.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tuser = cmd, tdata = text_byte
//  m_*       out  tvalid/tready      tdata = found, match_start, match_end
//  cfg_*     in   cfg_we             cfg_index selects register, cfg_wdata
//
// One item per cycle unless stalled. A byte is shifted into the window on its transfer;
// the window compare and match bookkeeping happen on the next edge. An end-of-buffer
// item loads the result register once no older result waits. Reset (rst, synchronous)
// clears config to defaults and all search state but the window. Bytes keep flowing
// while a result waits on m_tready; only a following end-of-buffer item stalls.
`timescale 1ns / 1ps

module wrapping_substring_search #(
  parameter int TERM_MAX      = wss_pkg::TERM_MAX_DEF,
  parameter int POSITION_BITS = wss_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wss_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] text_byte
  input  logic                              s_tuser,   // [0] cmd
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wss_pkg::M_DATA_W-1:0]      m_tdata,   // [0] found, [24:1] match_start,
                                                       // [49:25] match_end, rest zero
  input  logic                              cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CNT_W = POSITION_BITS + 1;
  localparam int CW    = (POSITION_BITS > wss_pkg::START_W) ? POSITION_BITS : wss_pkg::START_W;

  // configuration
  logic [TERM_MAX-1:0][wss_pkg::BYTE_W-1:0] term;
  logic [wss_pkg::LEN_W-1:0]                term_length;
  logic                                     case_sensitive;
  logic [wss_pkg::START_W-1:0]              start_position;

  // stage 1
  logic [TERM_MAX-1:0][wss_pkg::BYTE_W-1:0] window;
  logic [CNT_W-1:0]                         bytes_seen;
  logic                                     s1_valid;
  logic                                     s1_report;
  logic                                     s1_byte;

  // match state
  logic                                     later_valid;
  logic [POSITION_BITS-1:0]                 later_pos;
  logic                                     earlier_valid;
  logic [POSITION_BITS-1:0]                 earlier_pos;

  // result register
  logic                                     found;
  logic [wss_pkg::M_START_W-1:0]            match_start;
  logic [wss_pkg::M_END_W-1:0]              match_end;

  logic                                     stall;
  logic                                     accept;
  logic                                     saturated;
  logic                                     hit;
  logic [CNT_W-1:0]                         len_ext;
  logic [CNT_W-1:0]                         pos_diff;
  logic [POSITION_BITS-1:0]                 pos;
  logic                                     is_later;
  logic                                     len_reached;
  logic                                     byte_match;
  logic                                     report_go;
  logic                                     sel_found;
  logic [POSITION_BITS-1:0]                 sel_pos;
  logic [CNT_W-1:0]                         sel_end;
  logic [CW-1:0]                            sel_pos_ext;
  logic [CW:0]                              sel_end_ext;

  assign stall     = s1_valid && s1_report && m_tvalid && !m_tready;
  assign s_tready  = !stall;
  assign accept    = s_tvalid && s_tready;
  assign saturated = bytes_seen[POSITION_BITS];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      term           <= '0;
      term_length    <= '0;
      case_sensitive <= 1'b1;
      start_position <= '0;
    end else if (cfg_we) begin
      for (int j = 0; j < TERM_MAX; j++) begin
        if (cfg_index == wss_pkg::REG_TERM0 + wss_pkg::CFG_IDX_W'(j >> 3)) begin
          term[j] <= cfg_wdata[(j % 8) * 8 +: 8];
        end
      end
      if (cfg_index == wss_pkg::REG_TERM_LEN) begin
        term_length <= cfg_wdata[wss_pkg::LEN_W-1:0];
      end
      if (cfg_index == wss_pkg::REG_CASE_SENS) begin
        case_sensitive <= cfg_wdata[0];
      end
      if (cfg_index == wss_pkg::REG_START_POS) begin
        start_position <= cfg_wdata[wss_pkg::START_W-1:0];
      end
    end
  end

  // stage 1: window shift and byte count on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      s1_valid   <= 1'b0;
      s1_report  <= 1'b0;
      s1_byte    <= 1'b0;
    end else if (!stall) begin
      s1_valid  <= accept;
      s1_report <= accept && s_tuser;
      s1_byte   <= accept && !s_tuser && !saturated;
      if (accept) begin
        if (s_tuser) begin
          bytes_seen <= '0;
        end else if (!saturated) begin
          bytes_seen <= bytes_seen + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !s_tuser && !saturated) begin
      window[0] <= s_tdata[wss_pkg::BYTE_W-1:0];
      for (int k = 1; k < TERM_MAX; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  wss_matcher #(
    .TERM_MAX (TERM_MAX)
  ) u_matcher (
    .clk            (clk),
    .rst            (rst),
    .term           (term),
    .term_length    (term_length),
    .case_sensitive (case_sensitive),
    .window         (window),
    .hit            (hit)
  );

  // stage 2: match bookkeeping and result
  assign len_ext     = CNT_W'(term_length);
  assign len_reached = (bytes_seen >= len_ext);
  assign pos_diff    = bytes_seen - len_ext;
  assign pos         = pos_diff[POSITION_BITS-1:0];
  assign is_later    = (CW'(pos) >= CW'(start_position));
  assign byte_match  = s1_valid && s1_byte && hit && len_reached;
  assign report_go   = s1_valid && s1_report && !stall;

  always_comb begin
    sel_found = later_valid || earlier_valid;
    sel_pos   = later_valid ? later_pos : earlier_pos;
    sel_end   = CNT_W'(sel_pos) + len_ext;
    if (!sel_found) begin
      sel_pos = '0;
      sel_end = '0;
    end
    sel_pos_ext = CW'(sel_pos);
    sel_end_ext = (CW+1)'(sel_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      later_valid   <= 1'b0;
      later_pos     <= '0;
      earlier_valid <= 1'b0;
      earlier_pos   <= '0;
    end else if (report_go) begin
      later_valid   <= 1'b0;
      later_pos     <= '0;
      earlier_valid <= 1'b0;
      earlier_pos   <= '0;
    end else if (byte_match) begin
      if (is_later) begin
        if (!later_valid) begin
          later_valid <= 1'b1;
          later_pos   <= pos;
        end
      end else if (!earlier_valid) begin
        earlier_valid <= 1'b1;
        earlier_pos   <= pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (report_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (report_go) begin
      found       <= sel_found;
      match_start <= sel_pos_ext[wss_pkg::M_START_W-1:0];
      match_end   <= sel_end_ext[wss_pkg::M_END_W-1:0];
    end
  end

  assign m_tdata = {
    (wss_pkg::M_DATA_W - 1 - wss_pkg::M_START_W - wss_pkg::M_END_W)'(0),
    match_end, match_start, found
  };

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    saturated |-> (bytes_seen[POSITION_BITS-1:0] == '0))
    else $error("byte count beyond position bound");

  a_clear_after_report: assert property (@(posedge clk) disable iff (rst)
    report_go |=> (!later_valid && !earlier_valid))
    else $error("match state not cleared after report");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_valid && s1_report))
    else $error("result without end-of-buffer item");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !found) |-> (match_start == '0 && match_end == '0))
    else $error("nonzero offsets with no match");

  a_later_holds: assert property (@(posedge clk) disable iff (rst)
    (later_valid && !report_go) |=> (later_valid && $stable(later_pos)))
    else $error("first later match overwritten");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the wrapping substring search block.
`timescale 1ns / 1ps

module tb;

  localparam int WORDS       = 4;
  localparam int TERM_BYTES  = 32;
  localparam logic [24:0] POS_LIMIT = 25'h1000000;
  localparam int RAND_ITEMS  = 1600;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 600000;

  // characters just outside A..Z and a..z
  localparam wss_pkg::byte_t EDGE_CHARS [4] = '{8'h40, 8'h5B, 8'h60, 8'h7B};

  typedef enum logic {CMD_TEXT = 1'b0, CMD_END = 1'b1} cmd_t;
  typedef enum int {ALPHA_ANY, ALPHA_LETTERS, ALPHA_AB} alpha_t;

  typedef struct packed {
    cmd_t           cmd;
    wss_pkg::byte_t data;
  } feed_t;

  typedef struct packed {
    logic                          found;
    logic [wss_pkg::M_START_W-1:0] start_ofs;
    logic [wss_pkg::M_END_W-1:0]   end_ofs;
  } hit_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [wss_pkg::S_DATA_W-1:0]   s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [wss_pkg::M_DATA_W-1:0]   m_tdata;
  logic                           cfg_we = 1'b0;
  wss_pkg::cfg_idx_t              cfg_index = '0;
  logic [wss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  wrapping_substring_search DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Register copy and search state of the predictor.
  logic [63:0]    term_word [WORDS];
  logic [63:0]    pick_word [WORDS];
  logic [5:0]     term_size;
  logic           exact;
  logic [23:0]    start_at;
  wss_pkg::byte_t win [TERM_BYTES];
  logic [24:0]    seen;
  logic           later_ok, earlier_ok;
  logic [23:0]    later_at, earlier_at;

  feed_t feed_q[$];
  hit_t  results_due[$];

  int errors = 0;
  int n_bytes = 0, n_buffers = 0, n_later = 0, n_wrapped = 0, n_miss = 0, n_settings = 0;
  int queued = 0;
  int src_pct = 0, snk_pct = 0, src_gap = 0, snk_gap = 0;
  int holds_wanted = 0, holds_done = 0, hold_left = 0;
  int cycle_count = 0;
  logic  src_busy, snk_ready;
  feed_t cur;

  function automatic wss_pkg::byte_t fold_case(wss_pkg::byte_t c);
    if (!exact && c >= wss_pkg::CHAR_UPPER_A && c <= wss_pkg::CHAR_UPPER_Z)
      return c | wss_pkg::CASE_OFFSET;
    return c;
  endfunction

  function automatic logic is_letter(wss_pkg::byte_t c);
    return (c | wss_pkg::CASE_OFFSET) >= (wss_pkg::CHAR_UPPER_A | wss_pkg::CASE_OFFSET) &&
           (c | wss_pkg::CASE_OFFSET) <= (wss_pkg::CHAR_UPPER_Z | wss_pkg::CASE_OFFSET);
  endfunction

  task automatic clear_search();
    win = '{default: '0};
    seen = '0;
    later_ok = 1'b0;
    earlier_ok = 1'b0;
    later_at = '0;
    earlier_at = '0;
  endtask

  task automatic take_byte(wss_pkg::byte_t b);
    int k;
    logic hit;
    logic [24:0] at;
    n_bytes++;
    if (seen >= POS_LIMIT) return;
    for (k = TERM_BYTES - 1; k > 0; k--) win[k] = win[k - 1];
    win[0] = b;
    seen++;
    if (term_size == 0 || term_size > TERM_BYTES || seen < 25'(term_size)) return;
    hit = 1'b1;
    // term byte k lines up with the byte that arrived len-1-k transfers ago
    for (k = 0; k < int'(term_size); k++) begin
      if (fold_case(term_word[k / 8][(k % 8) * 8 +: 8]) !=
          fold_case(win[int'(term_size) - 1 - k])) hit = 1'b0;
    end
    if (!hit) return;
    at = seen - 25'(term_size);
    if (at >= {1'b0, start_at}) begin
      if (!later_ok) begin
        later_ok = 1'b1;
        later_at = at[23:0];
      end
    end else if (!earlier_ok) begin
      earlier_ok = 1'b1;
      earlier_at = at[23:0];
    end
  endtask

  task automatic take_end();
    hit_t h;
    h = '0;
    n_buffers++;
    if (later_ok) begin
      h.found = 1'b1;
      h.start_ofs = later_at;
      h.end_ofs = {1'b0, later_at} + 25'(term_size);
      n_later++;
    end else if (earlier_ok) begin
      h.found = 1'b1;
      h.start_ofs = earlier_at;
      h.end_ofs = {1'b0, earlier_at} + 25'(term_size);
      n_wrapped++;
    end else begin
      n_miss++;
    end
    results_due.push_back(h);
    clear_search();
  endtask

  task automatic check_result(logic [wss_pkg::M_DATA_W-1:0] d);
    hit_t want;
    logic f;
    logic [wss_pkg::M_START_W-1:0] s;
    logic [wss_pkg::M_END_W-1:0] e;
    f = d[0];
    s = d[wss_pkg::M_START_W:1];
    e = d[wss_pkg::M_START_W + wss_pkg::M_END_W:wss_pkg::M_START_W + 1];
    if (results_due.size() == 0) begin
      $error("result transfer with nothing pending: found=%0d start=%0d end=%0d", f, s, e);
      errors++;
      return;
    end
    want = results_due.pop_front();
    if (f !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, f);
      errors++;
    end
    if (s !== want.start_ofs) begin
      $error("match_start: expected %0d, got %0d", want.start_ofs, s);
      errors++;
    end
    if (e !== want.end_ofs) begin
      $error("match_end: expected %0d, got %0d", want.end_ofs, e);
      errors++;
    end
  endtask

  // Sender: predicts each item on its transfer, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      src_busy = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_END) take_end();
        else take_byte(s_tdata);
        if (src_pct > 0 && $urandom_range(0, 99) < src_pct) src_gap = $urandom_range(1, 19);
      end
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (feed_q.size() != 0) begin
          cur = feed_q.pop_front();
          s_tuser <= cur.cmd;
          s_tdata <= cur.data;
          src_busy = 1'b1;
        end
      end
      s_tvalid <= src_busy;
    end
  end

  // Receiver: checks each result transfer and throttles m_tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (hold_left > 0) begin
        hold_left--;
        snk_ready = 1'b0;
      end else if (holds_done < holds_wanted) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        snk_ready = 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        snk_ready = 1'b0;
      end else begin
        snk_ready = 1'b1;
        if (snk_pct > 0 && $urandom_range(0, 99) < snk_pct) snk_gap = $urandom_range(1, 19);
      end
      m_tready <= snk_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_byte(wss_pkg::byte_t b);
    feed_q.push_back('{cmd: CMD_TEXT, data: b});
    queued++;
  endtask

  task automatic push_end();
    feed_q.push_back('{cmd: CMD_END, data: wss_pkg::byte_t'($urandom)});
    queued++;
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic wss_pkg::byte_t text_char(alpha_t alpha);
    string letters;
    wss_pkg::byte_t c;
    letters = "abyz";
    case (alpha)
      ALPHA_ANY: c = wss_pkg::byte_t'($urandom);
      ALPHA_LETTERS: begin
        if ($urandom_range(0, 4) == 0) begin
          c = EDGE_CHARS[$urandom_range(0, 3)];
        end else begin
          c = letters[$urandom_range(0, 3)];
          if ($urandom_range(0, 1) == 1) c ^= wss_pkg::CASE_OFFSET;
        end
      end
      default: begin
        c = letters[$urandom_range(0, 1)];
        if ($urandom_range(0, 1) == 1) c ^= wss_pkg::CASE_OFFSET;
      end
    endcase
    return c;
  endfunction

  // Text drawn from the alphabet, with term copies (some bytes altered) spliced in.
  task automatic push_buffer(alpha_t alpha, int n);
    int i, k;
    logic flip;
    wss_pkg::byte_t c;
    i = 0;
    while (i < n) begin
      if (term_size >= 1 && term_size <= TERM_BYTES && $urandom_range(0, 99) < 20) begin
        flip = $urandom_range(0, 1);
        for (k = 0; k < int'(term_size); k++) begin
          c = term_word[k / 8][(k % 8) * 8 +: 8];
          if (flip && is_letter(c) && $urandom_range(0, 3) == 0) c ^= wss_pkg::CASE_OFFSET;
          else if ($urandom_range(0, 49) == 0) c = wss_pkg::byte_t'($urandom);
          push_byte(c);
        end
        i += int'(term_size);
      end else begin
        push_byte(text_char(alpha));
        i++;
      end
    end
    push_end();
  endtask

  task automatic write_reg(wss_pkg::cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // Writes every register (junk above the used bits) and updates the predictor.
  task automatic program_regs(logic [5:0] len, logic cs, logic [23:0] sp);
    int w;
    logic [63:0] v;
    for (w = 0; w < WORDS; w++)
      write_reg(wss_pkg::cfg_idx_t'(wss_pkg::REG_TERM0 + w), pick_word[w]);
    v = {$urandom, $urandom};
    v[wss_pkg::LEN_W-1:0] = len;
    write_reg(wss_pkg::REG_TERM_LEN, v);
    v = {$urandom, $urandom};
    v[0] = cs;
    write_reg(wss_pkg::REG_CASE_SENS, v);
    v = {$urandom, $urandom};
    v[wss_pkg::START_W-1:0] = sp;
    write_reg(wss_pkg::REG_START_POS, v);
    @(posedge clk);
    cfg_we <= 1'b0;
    for (w = 0; w < WORDS; w++) term_word[w] = pick_word[w];
    term_size = len;
    exact = cs;
    start_at = sp;
    n_settings++;
    @(negedge clk);
  endtask

  task automatic load_term(string s);
    int k;
    for (k = 0; k < WORDS; k++) pick_word[k] = {$urandom, $urandom};
    for (k = 0; k < s.len(); k++) pick_word[k / 8][(k % 8) * 8 +: 8] = s[k];
  endtask

  // Wait for every result, then let the trailing window compare finish.
  task automatic settle();
    while (feed_q.size() != 0 || s_tvalid || results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int phase, base, nbuf, b, n, k, roll, span;
    alpha_t alpha;
    logic [5:0] len;
    logic [23:0] sp;
    logic cs;

    for (k = 0; k < WORDS; k++) term_word[k] = '0;
    term_size = '0;
    exact = 1'b1;
    start_at = '0;
    clear_search();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_pct = 20;
    snk_pct = 20;
    // Reset defaults: empty term never matches.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_end();
    settle();
    // Folded compare; the characters just outside A..Z stay as they are.
    load_term("aB[");
    program_regs(6'd3, 1'b0, 24'd0);
    push_text("ab{xAb[");
    push_end();
    settle();
    // Zero bytes inside the term compare like any other byte.
    load_term("");
    pick_word[0][23:0] = 24'h00FF00;
    program_regs(6'd3, 1'b1, 24'd2);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_end();
    settle();
    // Later hit beats wrapped one, wrapped one alone, buffer shorter than term.
    load_term("ab");
    program_regs(6'd2, 1'b1, 24'd3);
    push_text("abxab");
    push_end();
    push_text("ab");
    push_end();
    push_text("a");
    push_end();
    settle();

    phase = 0;
    base = queued;
    while (queued - base < RAND_ITEMS || phase < 4) begin
      phase++;
      alpha = alpha_t'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      if (roll < 5) len = 6'd0;
      else if (roll < 10) len = 6'd32;
      else if (roll < 14) len = 6'($urandom_range(33, 63));
      else if (roll < 24) len = 6'($urandom_range(9, 31));
      else len = 6'($urandom_range(1, 8));
      if (phase == 1) len = 6'd32;
      if (phase == 2) len = 6'($urandom_range(33, 63));
      if (phase == 4) len = 6'd0;
      for (k = 0; k < WORDS; k++) pick_word[k] = {$urandom, $urandom};
      if (alpha != ALPHA_ANY) begin
        for (k = 0; k < TERM_BYTES; k++)
          pick_word[k / 8][(k % 8) * 8 +: 8] = text_char(alpha);
      end
      cs = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (roll < 20) sp = '0;
      else if (roll < 30) sp = 24'hFFFFFF;
      else if (roll < 40) sp = 24'($urandom);
      else sp = 24'($urandom_range(0, 40));
      if (phase == 1) sp = 24'hFFFFFF;
      program_regs(len, cs, sp);

      src_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      snk_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      if (queued - base > RAND_ITEMS - 300) begin
        src_pct = 0;
        snk_pct = 0;
      end
      span = (len > 6'd32) ? 32 : int'(len);
      if (phase == 3) begin
        // long receiver hold while many short buffers keep arriving
        src_pct = 0;
        holds_wanted++;
        for (b = 0; b < 30; b++) push_buffer(alpha, $urandom_range(0, 6));
      end else begin
        nbuf = $urandom_range(2, 10);
        for (b = 0; b < nbuf; b++) begin
          roll = $urandom_range(0, 99);
          if (roll < 10) n = 0;
          else if (roll < 15) n = $urandom_range(60, 120);
          else n = $urandom_range(1, 2 * span + 24);
          push_buffer(alpha, n);
        end
      end
      settle();
    end

    settle();
    repeat (8) @(negedge clk);
    $display("Covered %0d transfers (%0d text bytes) in %0d buffers over %0d register settings",
             queued, n_bytes, n_buffers, n_settings);
    $display("Results: %0d at/after start offset, %0d wrapped, %0d with no match",
             n_later, n_wrapped, n_miss);
    if (errors == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wss_pkg.sv
hdl/wss_matcher.sv
hdl/wrapping_substring_search.sv
bench/tb.sv
